// ----- design/pe_pkg.sv -----
// shared types, constants and helpers for the polynomial evaluator
package pe_pkg;

  localparam int MAX_DEGREE = 15;
  localparam int WIDTH      = 32;
  localparam int DEPTH      = MAX_DEGREE + 1;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W      = 8;
  localparam int DEG_W      = 5;
  localparam int FIELD_W    = 32;
  localparam int COEF_IDX_W = 4;
  localparam int IN_DATA_W  = 72;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t                 op;
    logic [COEF_IDX_W-1:0]   idx;
    logic [WIDTH-1:0]        coef;
    logic [WIDTH-1:0]        x;
    logic [WIDTH-1:0]        acc;
  } item_t;

  function automatic logic [WIDTH-1:0] to_width(input logic [FIELD_W-1:0] v);
    logic [63:0] e;
    e = {{(64 - FIELD_W){v[FIELD_W-1]}}, v};
    return e[WIDTH-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] from_width(input logic [WIDTH-1:0] a);
    logic [63:0] e;
    e = 64'($signed(a));
    return e[FIELD_W-1:0];
  endfunction

endpackage

// ----- design/polynomial_evaluate_core.sv -----
// top level of the pipelined polynomial evaluator
//
// Input words arrive on the s_ channel. s_tuser is the opcode: a load word
// writes coef_value into the coefficient of power coef_index, an evaluate
// word carries x_value and produces one result word on the m_ channel, the
// polynomial value at x wrapped to 32 bits. Load words produce no output.
// The degree register is written through the cfg_ channel; the user must
// write it only while the block is idle, which the block does not enforce.
// It resets to -1, the zero polynomial. The pipeline has one horner stage
// per coefficient, each one multiplier and one adder, highest power first.
// An evaluate word reaches m_tvalid through every stage register; one word
// can be accepted every cycle unless the output stalls. Loads travel
// through the same stages, so every evaluate sees exactly the coefficients
// loaded before it. Reset clears all valid bits; coefficients are undefined
// until loaded. When the receiver holds m_tready low with a result waiting,
// the whole pipeline freezes and s_tready drops; nothing is lost or repeated.
module polynomial_evaluate_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pe_pkg::DEG_W-1:0]     cfg_data,      // poly_degree
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [pe_pkg::IN_DATA_W-1:0] s_tdata,       // coef_index, coef_value, x_value, pad
  input  logic                         s_tuser,       // opcode
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [pe_pkg::FIELD_W-1:0]   m_tdata        // poly_result
);

  logic [pe_pkg::DEG_W-1:0] poly_degree;
  logic                     advance;
  logic                     valid_chain [pe_pkg::DEPTH+1];
  pe_pkg::item_t            item_chain  [pe_pkg::DEPTH+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      poly_degree <= '1;
    end else if (cfg_valid && cfg_ready) begin
      poly_degree <= cfg_data;
    end
  end

  assign advance  = !(valid_chain[pe_pkg::DEPTH] &&
                      (item_chain[pe_pkg::DEPTH].op == pe_pkg::OP_EVAL)) || m_tready;
  assign s_tready = advance;

  assign valid_chain[0]     = s_tvalid;
  assign item_chain[0].op   = pe_pkg::opcode_t'(s_tuser);
  assign item_chain[0].idx  = s_tdata[3:0];
  assign item_chain[0].coef = pe_pkg::to_width(s_tdata[35:4]);
  assign item_chain[0].x    = pe_pkg::to_width(s_tdata[67:36]);
  assign item_chain[0].acc  = '0;

  for (genvar g = 0; g < pe_pkg::DEPTH; g++) begin : g_stage
    pe_stage u_stage (
      .clk         (clk),
      .rst         (rst),
      .advance     (advance),
      .stage_index (pe_pkg::IDX_W'(pe_pkg::MAX_DEGREE - g)),
      .poly_degree (poly_degree),
      .in_valid    (valid_chain[g]),
      .in_item     (item_chain[g]),
      .out_valid   (valid_chain[g+1]),
      .out_item    (item_chain[g+1])
    );
  end

  assign m_tvalid = valid_chain[pe_pkg::DEPTH] &&
                    (item_chain[pe_pkg::DEPTH].op == pe_pkg::OP_EVAL);
  assign m_tdata  = pe_pkg::from_width(item_chain[pe_pkg::DEPTH].acc);

  a_reset_clears : assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_stall_freezes : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while output stalled");

  a_load_silent : assert property (@(posedge clk) disable iff (rst)
    (valid_chain[pe_pkg::DEPTH] && (item_chain[pe_pkg::DEPTH].op == pe_pkg::OP_LOAD))
      |-> !m_tvalid)
    else $error("load word produced a result");

endmodule

// ----- design/pe_stage.sv -----
// one horner step: coefficient register, multiply by x and add
module pe_stage (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  logic [pe_pkg::IDX_W-1:0] stage_index,
  input  logic [pe_pkg::DEG_W-1:0] poly_degree,
  input  logic                     in_valid,
  input  pe_pkg::item_t            in_item,
  output logic                     out_valid,
  output pe_pkg::item_t            out_item
);

  logic [pe_pkg::WIDTH-1:0] coef;
  logic [pe_pkg::WIDTH-1:0] term;
  logic [pe_pkg::WIDTH-1:0] product;
  logic                     in_use;
  logic                     load_hit;
  pe_pkg::item_t            item_next;

  assign load_hit = in_valid && (in_item.op == pe_pkg::OP_LOAD) &&
                    (pe_pkg::CMP_W'(in_item.idx) == pe_pkg::CMP_W'(stage_index));

  // negative degree means zero polynomial
  assign in_use = !poly_degree[pe_pkg::DEG_W-1] &&
                  (pe_pkg::CMP_W'(stage_index) <=
                   pe_pkg::CMP_W'(poly_degree[pe_pkg::DEG_W-2:0]));

  assign term    = in_use ? coef : '0;
  assign product = in_item.acc * in_item.x;

  always_comb begin
    item_next     = in_item;
    item_next.acc = product + term;
  end

  always_ff @(posedge clk) begin
    if (advance && load_hit) begin
      coef <= in_item.coef;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= item_next;
    end
  end

endmodule
